/* sv/sorted_insert_list_unit_macros.svh */
// Assertion macros used by the sorted insert list RTL.
`ifndef SORTED_INSERT_LIST_UNIT_MACROS_SVH
`define SORTED_INSERT_LIST_UNIT_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define SIL_ASSERT_ALWAYS(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("sorted insert list: invariant violated");

// Check that a trigger implies a condition in the same cycle.
`define SIL_ASSERT_IMPLY(label, trig, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) \
    else $error("sorted insert list: implication violated");

// Check that a trigger implies a condition in the next cycle.
`define SIL_ASSERT_NEXT(label, trig, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
    else $error("sorted insert list: next-cycle check violated");

`endif

/* sv/sil_pkg.sv */
// Constants and types of the sorted insert list unit.
package sil_pkg;

  localparam int DEPTH   = 16;
  localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int POS_W   = 4;
  localparam int CMP_W   = (CNT_W > POS_W) ? CNT_W : POS_W;
  localparam int VALUE_W = 32;
  localparam int CMD_W   = 2;
  localparam int STAT_W  = 2;
  localparam int OCNT_W  = 5;

  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_READ   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] ST_RANGE = 2'd2;

  typedef logic [ADDR_W-1:0]         addr_t;
  typedef logic [CNT_W-1:0]          count_t;
  typedef logic signed [VALUE_W-1:0] value_t;

endpackage

/* sv/sil_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module sil_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                    clk,
  input  logic                                    wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                        wr_data,
  input  logic                                    rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                        rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* sv/sorted_insert_list_unit.sv */
// Sorted insert list: an ascending table of signed values held in one RAM.
// Clear, unused and refused commands go straight to the output stage; a read waits for
// its RAM data first, and an insert scans down past each stored entry greater than the value
// (an insert into an empty table writes its value directly).
// One item at a time: the insert scan reads one RAM entry per cycle, shifting it up.
// Next item is accepted the cycle after the result is loaded into the output register.
// Synchronous reset empties the table and clears control state; RAM contents are left as is.
`include "sorted_insert_list_unit_macros.svh"

module sorted_insert_list_unit
  import sil_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // s_tdata fields from bit 0: value[31:0], position[35:32], zero pad[39:36]
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,
  // s_tuser fields from bit 0: cmd[1:0]
  input  logic [1:0]  s_tuser,
  // m_tdata fields from bit 0: read_value[31:0], stored_count[36:32], zero pad[39:37]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,
  // m_tuser fields from bit 0: status[1:0]
  output logic [1:0]  m_tuser
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_PLACE = 3'd2;
  localparam logic [2:0] S_RDATA = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0]        state;
  count_t            count;
  addr_t             k;
  value_t            ins_value;
  logic [STAT_W-1:0] res_status;
  value_t            res_value;

  logic              accept;
  logic [CMD_W-1:0]  in_cmd;
  value_t            in_value;
  logic [POS_W-1:0]  in_pos;
  logic              is_full;
  logic              in_range;
  logic              greater;

  logic              wr_en;
  addr_t             wr_addr;
  logic [VALUE_W-1:0] wr_data;
  logic              rd_en;
  addr_t             rd_addr;
  logic [VALUE_W-1:0] rd_data;

  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign in_cmd   = s_tuser;
  assign in_value = s_tdata[31:0];
  assign in_pos   = s_tdata[35:32];
  assign is_full  = (count >= CNT_W'(DEPTH));
  assign in_range = (CMP_W'(in_pos) < CMP_W'(count));
  assign greater  = ($signed(rd_data) > ins_value);

  // Entry storage
  sil_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Drive RAM ports: read the next lower entry while writing the shifted one up
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = '0;
    wr_data = rd_data;
    rd_en   = 1'b0;
    rd_addr = '0;
    unique case (state)
      S_IDLE: begin
        if (accept && in_cmd == CMD_INSERT && !is_full) begin
          if (count == '0) begin
            wr_en   = 1'b1;
            wr_data = in_value;
          end else begin
            rd_en   = 1'b1;
            rd_addr = ADDR_W'(count - 1'b1);
          end
        end else if (accept && in_cmd == CMD_READ && in_range) begin
          rd_en   = 1'b1;
          rd_addr = ADDR_W'(in_pos);
        end
      end
      S_SCAN: begin
        wr_en   = 1'b1;
        wr_addr = ADDR_W'(k + 1'b1);
        wr_data = greater ? rd_data : ins_value;
        if (greater && k != '0) begin
          rd_en   = 1'b1;
          rd_addr = ADDR_W'(k - 1'b1);
        end
      end
      S_PLACE: begin
        wr_en   = 1'b1;
        wr_data = ins_value;
      end
      default: begin
      end
    endcase
  end

  // Sequence each command and hold its result until the output register is free
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && state != S_DONE) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            ins_value <= in_value;
            res_value <= '0;
            unique case (in_cmd)
              CMD_INSERT: begin
                if (is_full) begin
                  res_status <= ST_FULL;
                  state      <= S_DONE;
                end else if (count == '0) begin
                  res_status <= ST_OK;
                  count      <= count + 1'b1;
                  state      <= S_DONE;
                end else begin
                  res_status <= ST_OK;
                  k          <= ADDR_W'(count - 1'b1);
                  state      <= S_SCAN;
                end
              end
              CMD_READ: begin
                if (in_range) begin
                  res_status <= ST_OK;
                  state      <= S_RDATA;
                end else begin
                  res_status <= ST_RANGE;
                  state      <= S_DONE;
                end
              end
              CMD_CLEAR: begin
                res_status <= ST_OK;
                count      <= '0;
                state      <= S_DONE;
              end
              default: begin
                res_status <= ST_OK;
                state      <= S_DONE;
              end
            endcase
          end
        end
        S_SCAN: begin
          if (!greater) begin
            count <= count + 1'b1;
            state <= S_DONE;
          end else if (k == '0) begin
            state <= S_PLACE;
          end else begin
            k <= k - 1'b1;
          end
        end
        S_PLACE: begin
          count <= count + 1'b1;
          state <= S_DONE;
        end
        S_RDATA: begin
          res_value <= rd_data;
          state     <= S_DONE;
        end
        S_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tuser  <= res_status;
            m_tdata  <= {3'b000, OCNT_W'(count), res_value};
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Table never holds more than its depth
  `SIL_ASSERT_ALWAYS(a_count_bound, count <= CNT_W'(DEPTH))
  // Shift write and next read never touch the same entry
  `SIL_ASSERT_IMPLY(a_no_rw_clash, wr_en && rd_en && state == S_SCAN, wr_addr != rd_addr)
  // Scan index stays inside the stored entries
  `SIL_ASSERT_IMPLY(a_scan_index, state == S_SCAN, CNT_W'(k) < count)
  // A refused insert only happens on a full table
  `SIL_ASSERT_IMPLY(a_full_status, state == S_DONE && res_status == ST_FULL,
    count == CNT_W'(DEPTH))
  // An insert that scans down to the bottom entry grows the table by one when it finishes
  `SIL_ASSERT_NEXT(a_place_grows, state == S_PLACE, count == $past(count) + 1'b1)

endmodule
